/* rtl/ola_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ola_pkg: shared definitions for the ordered list block
// Action and status codes plus the fixed field widths of the stream ports.
// ----------------------------------------------------------------------------
package ola_pkg;

    localparam int ITEM_W   = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Result stream data is padded up to whole bytes.
    localparam int M_DATA_W = ((ITEM_W + COUNT_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - ITEM_W - COUNT_W;

    localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISPLAY = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

endpackage

/* rtl/ola_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ola_ram: simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value on cycles without a read enable.
// ----------------------------------------------------------------------------
module ola_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/ordered_list_append_delete.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_delete: bounded ordered list with append/delete/display
// Keeps up to CAPACITY signed 32-bit values in arrival order in a RAM and
// walks it under a small sequencer for delete and display.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata                         | tuser       | tlast
//  s_      | in        | value[31:0]                   | action[1:0] | -
//  m_      | out       | item[31:0], count[36:32], pad | status[1:0] | last
//
// Append writes the RAM on the accepting edge, then issues the result. Delete
// is paced by the single RAM read port, which scans and then shifts one entry
// per cycle. Display reads one entry per cycle through the same read port
// while the result channel is not stalled.
// Reset clears the length and the sequencer; list contents are not cleared.
// A stalled result channel holds the sequencer in its display-output and
// result states; s_tready is high only while the sequencer is idle.
// ----------------------------------------------------------------------------
module ordered_list_append_delete
    import ola_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ITEM_W-1:0]   s_tdata,   // value (signed)
    input  logic [ACTION_W-1:0] s_tuser,   // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // item (signed), count, zero pad
    output logic [STATUS_W-1:0] m_tuser,   // status
    output logic                m_tlast    // last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL_RD,
        ST_DEL_CMP,
        ST_SHIFT,
        ST_DISP_RD,
        ST_DISP_OUT,
        ST_RESULT
    } state_t;

    state_t                state_reg, state_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [ITEM_W-1:0]     value_reg, value_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic                  m_valid_reg, m_valid_next;
    logic [ITEM_W-1:0]     m_item_reg, m_item_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;
    logic                  m_last_reg, m_last_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ITEM_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [ITEM_W-1:0]     ram_rdata;

    logic [LW-1:0]         nxt1;
    logic [LW:0]           nxt2;
    logic                  out_free;

    assign nxt1     = LW'(idx_reg) + LW'(1);
    assign nxt2     = (LW + 1)'(idx_reg) + (LW + 1)'(2);
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_reg, m_item_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    ola_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_item_next   = m_item_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    value_next = s_tdata;
                    idx_next   = '0;
                    case (s_tuser)
                        ACT_APPEND: begin
                            if (len_reg < LW'(CAPACITY)) begin
                                ram_we      = 1'b1;
                                ram_waddr   = len_reg[AW-1:0];
                                ram_wdata   = s_tdata;
                                len_next    = len_reg + LW'(1);
                                status_next = STAT_OK;
                            end else begin
                                status_next = STAT_FULL;
                            end
                            state_next = ST_RESULT;
                        end
                        ACT_DELETE: begin
                            if (len_reg == '0) begin
                                status_next = STAT_EMPTY;
                                state_next  = ST_RESULT;
                            end else begin
                                state_next = ST_DEL_RD;
                            end
                        end
                        ACT_DISPLAY: begin
                            if (len_reg == '0) begin
                                status_next = STAT_EMPTY;
                                state_next  = ST_RESULT;
                            end else begin
                                state_next = ST_DISP_RD;
                            end
                        end
                        default: begin
                            // Unused action code: the transaction is dropped.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DEL_RD: begin
                ram_re     = 1'b1;
                state_next = ST_DEL_CMP;
            end
            ST_DEL_CMP: begin
                // Read data holds the entry at idx_reg.
                if (ram_rdata == value_reg) begin
                    if (nxt1 < len_reg) begin
                        ram_re     = 1'b1;
                        ram_raddr  = nxt1[AW-1:0];
                        state_next = ST_SHIFT;
                    end else begin
                        len_next    = len_reg - LW'(1);
                        status_next = STAT_OK;
                        state_next  = ST_RESULT;
                    end
                end else if (nxt1 < len_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = nxt1[AW-1:0];
                    idx_next  = nxt1[AW-1:0];
                end else begin
                    status_next = STAT_NOTFOUND;
                    state_next  = ST_RESULT;
                end
            end
            ST_SHIFT: begin
                // Read data holds the entry after idx_reg; move it down one slot.
                ram_we   = 1'b1;
                idx_next = nxt1[AW-1:0];
                if (nxt2 < (LW + 1)'(len_reg)) begin
                    ram_re    = 1'b1;
                    ram_raddr = nxt2[AW-1:0];
                end else begin
                    len_next    = len_reg - LW'(1);
                    status_next = STAT_OK;
                    state_next  = ST_RESULT;
                end
            end
            ST_DISP_RD: begin
                ram_re     = 1'b1;
                state_next = ST_DISP_OUT;
            end
            ST_DISP_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_item_next   = ram_rdata;
                    m_status_next = STAT_OK;
                    m_count_next  = COUNT_W'(len_reg);
                    m_last_next   = (nxt1 == len_reg);
                    if (nxt1 == len_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = nxt1[AW-1:0];
                        idx_next  = nxt1[AW-1:0];
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_item_next   = '0;
                    m_status_next = status_reg;
                    m_count_next  = COUNT_W'(len_reg);
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg      <= idx_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        m_item_reg   <= m_item_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    // The list never holds more entries than its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(CAPACITY))
        else $error("list length exceeds capacity");

    // Only a display produces results that are not the last of their item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == STAT_OK)
        else $error("non-final result with a non-ok status");

    // An empty-list status always reports a count of zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_EMPTY |-> m_tdata[ITEM_W +: COUNT_W] == '0)
        else $error("empty status with nonzero count");

    // An append to a full list leaves the length unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_APPEND && len_reg == LW'(CAPACITY)
        |=> $stable(len_reg))
        else $error("append to full list changed the length");

endmodule
